// File: src/sfc_pkg.sv
// sfc_pkg: shared types and constants for the sfc32 bounded random block
// no dependencies
package sfc_pkg;

  localparam int FracBits    = 16;
  localparam int WarmupSteps = 16;

  localparam logic [31:0] ResetFirst  = 32'h4A3B6035;
  localparam logic [31:0] ResetSecond = 32'h99555606;
  localparam logic [31:0] ResetThird  = 32'h6F603421;
  localparam logic [31:0] ResetCount  = 32'd16;

  typedef enum logic [2:0] {
    CMD_SEED    = 3'd0,
    CMD_RAW     = 3'd1,
    CMD_FRAC    = 3'd2,
    CMD_BYTE    = 3'd3,
    CMD_KEY     = 3'd4,
    CMD_RANGE   = 3'd5,
    CMD_NONZERO = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WARM,
    ST_DRAW,
    ST_KMUL,
    ST_KCHK,
    ST_MOD,
    ST_KDRAW,
    ST_KMUL2,
    ST_KCHK2,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction, seed words load here
    logic seed;      // restart warm-up count
    logic step;      // advance generator
    logic mul;       // register product of word and limit
    logic mod_start; // start threshold remainder
    logic mod_step;  // one restoring division step
    logic fin;       // form the result
    logic out_take;  // result taken
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic limit_zero;
    logic low_lt_limit;
    logic low_lt_thresh;
    logic word_zero;
    logic mod_done;
    logic warm_done;
  } dp_stat_t;

endpackage

// File: src/sfc_ctrl.sv
// sfc_ctrl: controller state machine for the sfc32 bounded random block
// depends on sfc_pkg
module sfc_ctrl import sfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        unique case (stat.cmd)
          CMD_SEED: begin
            cmd.seed  = 1'b1;
            state_nxt = ST_WARM;
          end
          CMD_RAW, CMD_FRAC, CMD_BYTE: begin
            cmd.step  = 1'b1;
            state_nxt = ST_OUT;
          end
          CMD_NONZERO: begin
            cmd.step = 1'b1;
            if (!stat.word_zero) state_nxt = ST_OUT;
          end
          CMD_KEY, CMD_RANGE: begin
            if (stat.limit_zero) state_nxt = ST_OUT;
            else begin
              cmd.step  = 1'b1;
              state_nxt = ST_KMUL;
            end
          end
          default: state_nxt = ST_OUT;
        endcase
        if (state_nxt == ST_OUT) cmd.fin = 1'b1;
      end
      ST_WARM: begin
        if (stat.warm_done) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_OUT;
        end else cmd.step = 1'b1;
      end
      ST_KMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_KCHK;
      end
      ST_KCHK: begin
        if (stat.low_lt_limit) begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_MOD;
        end else begin
          cmd.fin   = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_MOD: begin
        if (stat.mod_done) state_nxt = ST_KCHK2;
        else cmd.mod_step = 1'b1;
      end
      ST_KCHK2: begin
        if (stat.low_lt_thresh) state_nxt = ST_KDRAW;
        else begin
          cmd.fin   = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_KDRAW: begin
        cmd.step  = 1'b1;
        state_nxt = ST_KMUL2;
      end
      ST_KMUL2: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_KCHK2;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_take = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: src/sfc_dp.sv
// sfc_dp: generator state, multiplier, divider and result register
// depends on sfc_pkg
module sfc_dp import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_seed_first,
  input  logic [31:0] in_seed_second,
  input  logic [31:0] in_seed_third,
  input  logic [1:0]  in_seed_num,
  input  logic [31:0] in_arg_a,
  input  logic [31:0] in_arg_b,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [31:0] out_value
);

  localparam int WarmW = $clog2(WarmupSteps + 1);

  logic [31:0] first_r, second_r, third_r, count_r;
  cmd_t        cmd_r;
  logic [31:0] lo_r, limit_r, word_r, value_r;
  logic        neg_r;
  logic [63:0] prod_r;
  logic [31:0] rem_r, quo_r, thresh_r;
  logic [5:0]  mod_cnt_r;
  logic        mod_busy_r;
  logic [WarmW-1:0] warm_r;

  logic [31:0] t_word;
  logic [31:0] lim_key, lim_rng, a_lo, a_hi;
  logic        swap;
  logic [32:0] rem_sh;

  // one generator step output
  assign t_word = first_r + second_r + count_r;

  // limit for key and range
  assign swap    = $signed(in_arg_b) < $signed(in_arg_a);
  assign a_lo    = swap ? in_arg_b : in_arg_a;
  assign a_hi    = swap ? in_arg_a : in_arg_b;
  assign lim_key = in_arg_a[31] ? (32'd0 - in_arg_a) : in_arg_a;
  assign lim_rng = a_hi - a_lo + 32'd1;

  // generator state, seed words load with the accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= ResetFirst;
      second_r <= ResetSecond;
      third_r  <= ResetThird;
      count_r  <= ResetCount;
    end else if (cmd.load && (in_command == CMD_SEED)) begin
      count_r  <= 32'd1;
      third_r  <= (in_seed_num > 2'd0) ? in_seed_first  : 32'd0;
      second_r <= (in_seed_num > 2'd1) ? in_seed_second : 32'd0;
      first_r  <= (in_seed_num > 2'd2) ? in_seed_third  : 32'd0;
    end else if (cmd.step) begin
      count_r  <= count_r + 32'd1;
      first_r  <= second_r ^ (second_r >> 9);
      second_r <= third_r * 32'd9;
      third_r  <= {third_r[10:0], third_r[31:11]} + t_word;
    end
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (!rst_n) cmd_r <= CMD_NONE;
    else if (cmd.load) cmd_r <= cmd_t'(in_command);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r   <= (in_command == CMD_KEY) && in_arg_a[31];
      lo_r    <= (in_command == CMD_RANGE) ? a_lo : 32'd0;
      limit_r <= (in_command == CMD_RANGE) ? lim_rng : lim_key;
    end
    if (cmd.step) word_r <= t_word;
    if (cmd.mul)  prod_r <= {32'd0, word_r} * {32'd0, limit_r};
  end

  // warm-up counter
  always_ff @(posedge clk) begin
    if (!rst_n)       warm_r <= '0;
    else if (cmd.seed) warm_r <= '0;
    else if (cmd.step) warm_r <= warm_r + 1'b1;
  end

  // restoring division of (2^32 - limit) by limit, one bit per cycle
  assign rem_sh = {rem_r, quo_r[31]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_busy_r <= 1'b0;
      mod_cnt_r  <= '0;
    end else if (cmd.mod_start) begin
      mod_busy_r <= 1'b1;
      mod_cnt_r  <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt_r <= mod_cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      rem_r <= '0;
      quo_r <= 32'd0 - limit_r;
    end else if (cmd.mod_step) begin
      quo_r <= {quo_r[30:0], 1'b0};
      if (rem_sh >= {1'b0, limit_r}) rem_r <= rem_sh[31:0] - limit_r;
      else                           rem_r <= rem_sh[31:0];
    end
  end
  assign thresh_r = rem_r;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      unique case (cmd_r)
        CMD_RAW, CMD_NONZERO: value_r <= t_word;
        CMD_FRAC:  value_r <= t_word >> (32 - FracBits);
        CMD_BYTE:  value_r <= t_word >> 24;
        CMD_KEY, CMD_RANGE: begin
          if (limit_r == 32'd0) value_r <= lo_r;
          else if (neg_r) value_r <= 32'd0 - prod_r[63:32];
          else            value_r <= prod_r[63:32] + lo_r;
        end
        default: value_r <= 32'd0;
      endcase
    end
  end

  assign out_value = value_r;

  always_comb begin
    stat               = '0;
    stat.cmd           = cmd_r;
    stat.limit_zero    = (limit_r == 32'd0);
    stat.low_lt_limit  = prod_r[31:0] < limit_r;
    stat.low_lt_thresh = prod_r[31:0] < thresh_r;
    stat.word_zero     = (t_word == 32'd0);
    stat.mod_done      = mod_busy_r && (mod_cnt_r == 6'd32);
    stat.warm_done     = (warm_r == WarmW'(WarmupSteps));
  end

endmodule

// File: src/sfc32_bounded_random.sv
// sfc32_bounded_random: top level joining controller and datapath
// depends on sfc_pkg, sfc_ctrl, sfc_dp
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    command, seed words, seed_num, arg_a, arg_b
// out      output     out_valid / out_ready  value
//
// one transaction at a time; raw, fraction, byte: a generator step, then the result
// seed: a warm-up of 16 generator steps and the done check
// key and range: draw, multiply and check, plus the bit-serial remainder and its
// check when the low product half is under the limit, plus a redraw per retry
// synchronous active-low reset loads the default generator state
// a stalled result holds the block until taken
module sfc32_bounded_random import sfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_seed_first,
  input  logic [31:0] in_seed_second,
  input  logic [31:0] in_seed_third,
  input  logic [1:0]  in_seed_num,
  input  logic signed [31:0] in_arg_a,
  input  logic signed [31:0] in_arg_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sfc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  sfc_dp u_dp (
    .clk, .rst_n, .in_command, .in_seed_first, .in_seed_second, .in_seed_third,
    .in_seed_num, .in_arg_a, .in_arg_b, .cmd, .stat, .out_value
  );

  // never ready and valid together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // a result leaves only through the handshake
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result dropped");

  // an accepted transaction blocks further input next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("double accept");

endmodule

// File: sim/tb.sv
// tb: self-checking testbench for sfc32_bounded_random
// depends on sfc_pkg and the sfc32_bounded_random rtl
module tb;
  import sfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = CMD_RAW;
  logic [31:0] in_seed_first = '0;
  logic [31:0] in_seed_second = '0;
  logic [31:0] in_seed_third = '0;
  logic [1:0]  in_seed_num = '0;
  logic signed [31:0] in_arg_a = '0;
  logic signed [31:0] in_arg_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_value;

  sfc32_bounded_random dut (.*);

  always #10 clk = ~clk;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] s1, s2, s3;
    logic [1:0]  cnt;
    logic [31:0] a, b;
    bit          fixed;   // expected value typed in
    logic [31:0] value;
  } request_t;

  // generator copy
  logic [31:0] gw1, gw2, gw3, gcnt;
  logic [31:0] value_q[$];
  int errors = 0;
  int items_out = 0;

  function automatic logic [31:0] gen_next();
    logic [31:0] t;
    logic [31:0] c;
    t = gw1 + gw2 + gcnt;
    c = gw3;
    gcnt = gcnt + 1;
    gw1 = gw2 ^ (gw2 >> 9);
    gw2 = c * 32'd9;
    gw3 = {c[10:0], c[31:11]} + t;
    return t;
  endfunction

  // unbiased key in [0, limit) by multiply and reject
  function automatic logic [31:0] bounded_key(logic [31:0] limit);
    logic [63:0] prod;
    logic [31:0] thresh;
    if (limit == 0) return 32'd0;
    prod = {32'd0, gen_next()} * {32'd0, limit};
    if (prod[31:0] < limit) begin
      thresh = (32'd0 - limit) % limit;
      while (prod[31:0] < thresh)
        prod = {32'd0, gen_next()} * {32'd0, limit};
    end
    return prod[63:32];
  endfunction

  function automatic logic [31:0] predict_value(request_t r);
    logic [31:0] mag, lo, hi, v;
    v = '0;
    case (r.cmd)
      CMD_SEED: begin
        gcnt = 32'd1;
        gw3 = (r.cnt > 0) ? r.s1 : '0;
        gw2 = (r.cnt > 1) ? r.s2 : '0;
        gw1 = (r.cnt > 2) ? r.s3 : '0;
        for (int i = 0; i < WarmupSteps; i++) void'(gen_next());
      end
      CMD_RAW:  v = gen_next();
      CMD_FRAC: v = gen_next() >> (32 - FracBits);
      CMD_BYTE: v = gen_next() >> 24;
      CMD_KEY: begin
        mag = r.a[31] ? -r.a : r.a;
        v = bounded_key(mag);
        if (r.a[31]) v = -v;
      end
      CMD_RANGE: begin
        lo = r.a; hi = r.b;
        if ($signed(r.b) < $signed(r.a)) begin
          lo = r.b; hi = r.a;
        end
        v = bounded_key(hi - lo + 1) + lo;
      end
      CMD_NONZERO: begin
        do v = gen_next(); while (v == 0);
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch %s got %h want %h", what, got, want);
    errors++;
  endtask

  // valid stays high into the next transaction when no idle cycles are drawn
  task automatic send_request(request_t r);
    logic [31:0] v;
    int idle;
    idle = $urandom_range(0, 11);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    v = predict_value(r);
    if (r.fixed && v != r.value) report_mismatch("table row", r.value, v);
    value_q.push_back(r.fixed ? r.value : v);
    in_valid       <= 1'b1;
    in_command     <= r.cmd;
    in_seed_first  <= r.s1;
    in_seed_second <= r.s2;
    in_seed_third  <= r.s3;
    in_seed_num    <= r.cnt;
    in_arg_a       <= r.a;
    in_arg_b       <= r.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic request_t mk(cmd_t c, logic [31:0] a = 0, logic [31:0] b = 0,
                                  logic [1:0] cnt = 0, logic [31:0] s1 = 0,
                                  logic [31:0] s2 = 0, logic [31:0] s3 = 0,
                                  bit fixed = 0, logic [31:0] value = 0);
    request_t r;
    r.cmd = c; r.a = a; r.b = b; r.cnt = cnt;
    r.s1 = s1; r.s2 = s2; r.s3 = s3; r.fixed = fixed; r.value = value;
    return r;
  endfunction

  // result side: random stalls, compare with oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        items_out++;
        if (value_q.size() == 0) report_mismatch("unexpected transaction", out_value, 32'd0);
        else begin
          logic [31:0] want;
          want = value_q.pop_front();
          if (out_value !== want) report_mismatch("value", out_value, want);
        end
        stall_left = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    #50ms;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    request_t tbl[$];
    request_t r;
    logic [31:0] x, y;
    gw1 = ResetFirst; gw2 = ResetSecond; gw3 = ResetThird; gcnt = ResetCount;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: reset state, extremes, special cases
    tbl.push_back(mk(CMD_RAW, 0, 0, 0, 0, 0, 0, 1,
                     32'h4A3B6035 + 32'h99555606 + 32'd16));
    tbl.push_back(mk(CMD_KEY, 0, 0, 0, 0, 0, 0, 1, 32'd0));
    tbl.push_back(mk(CMD_RANGE, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 1, 32'h80000000));
    tbl.push_back(mk(CMD_RANGE, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 1, 32'h80000000));
    tbl.push_back(mk(CMD_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 3, '1, '1, '1, 1, 32'd0));
    tbl.push_back(mk(CMD_FRAC));
    tbl.push_back(mk(CMD_BYTE));
    tbl.push_back(mk(CMD_NONZERO));
    tbl.push_back(mk(CMD_KEY, 32'h80000000));
    tbl.push_back(mk(CMD_KEY, 32'h7FFFFFFF));
    tbl.push_back(mk(CMD_KEY, 32'hFFFFFFFF));
    tbl.push_back(mk(CMD_KEY, 32'd1));
    tbl.push_back(mk(CMD_KEY, 32'd3));
    tbl.push_back(mk(CMD_RANGE, 32'd5, 32'd5));
    tbl.push_back(mk(CMD_RANGE, 32'd10, 32'hFFFFFFF6));
    tbl.push_back(mk(CMD_SEED, 0, 0, 0, '1, '1, '1, 1, 32'd0));
    tbl.push_back(mk(CMD_RAW));
    tbl.push_back(mk(CMD_NONZERO));
    tbl.push_back(mk(CMD_SEED, 0, 0, 1, 32'h12345678, '1, '1, 1, 32'd0));
    tbl.push_back(mk(CMD_RAW));
    tbl.push_back(mk(CMD_SEED, 0, 0, 2, '1, '1, '1, 1, 32'd0));
    tbl.push_back(mk(CMD_FRAC));
    tbl.push_back(mk(CMD_SEED, 0, 0, 3, '1, 32'hA5A5A5A5, '1, 1, 32'd0));
    tbl.push_back(mk(CMD_BYTE));
    foreach (tbl[i]) send_request(tbl[i]);

    // hold off until every expected transaction is back
    in_valid <= 1'b0;
    while (value_q.size() != 0) @(posedge clk);

    // random part
    for (int n = 0; n < 1550; n++) begin
      x = $urandom(); y = $urandom();
      case ($urandom_range(0, 3))
        0: x = $urandom_range(0, 20);
        1: x = x >> $urandom_range(0, 31);
        2: x = -($urandom_range(0, 20));
        default: ;
      endcase
      if ($urandom_range(0, 1)) y = x + ($urandom_range(0, 40) - 20);
      r = mk(cmd_t'($urandom_range(0, 7)), x, y, 2'($urandom_range(0, 3)),
             $urandom(), $urandom(), $urandom());
      if (r.cmd == CMD_SEED && $urandom_range(0, 3) != 0) r.cmd = CMD_RANGE;
      send_request(r);
      if (n == 700) begin
        in_valid <= 1'b0;
        while (value_q.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (value_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && value_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

// File: files.f
src/sfc_pkg.sv
src/sfc_ctrl.sv
src/sfc_dp.sv
src/sfc32_bounded_random.sv
sim/tb.sv
